FILE: hw/rtl/csx_pkg.sv
`default_nettype none
// shared constants, codes and ctrl/datapath bundles for the collinear segment extent block
package csx_pkg;

    localparam int COORD_BITS     = 12;
    localparam int RHO_BITS       = 18;
    localparam int TRIG_BITS      = 16;
    localparam int TOL_BITS       = 16;
    localparam int FRAC_ALIGN     = 10;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 18;

    localparam int MUL_BITS  = ((COORD_BITS + 1 > TRIG_BITS) ? COORD_BITS + 1 : TRIG_BITS) + 1;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RHO    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COS    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIN    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOL    = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ABSENT = CFG_INDEX_BITS'(4);

    localparam logic signed [RHO_BITS-1:0]  RHO_RESET = '0;
    localparam logic signed [TRIG_BITS-1:0] COS_RESET = TRIG_BITS'(16384);
    localparam logic signed [TRIG_BITS-1:0] SIN_RESET = '0;
    localparam logic [TOL_BITS-1:0]         TOL_RESET = TOL_BITS'(80);

    typedef enum logic [2:0] {
        OP_LINE_A,
        OP_LINE_B,
        OP_RAD_A,
        OP_RAD_B,
        OP_D_E2P1,
        OP_SPAN1,
        OP_D_E1P2,
        OP_SPAN2
    } op_t;

    typedef struct packed {
        logic capture;
        logic acc;
        logic emit;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic near;
        logic bounds_zero;
        logic line_absent;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/csx_dp.sv
`default_nettype none
// datapath: config registers, shared multiplier pair, accumulator, bounds and result register
module csx_dp
    import csx_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic [COORD_BITS-1:0]     seg_ax,
    input  wire logic [COORD_BITS-1:0]     seg_ay,
    input  wire logic [COORD_BITS-1:0]     seg_bx,
    input  wire logic [COORD_BITS-1:0]     seg_by,
    input  wire dp_cmd_t                   cmd,
    output dp_sts_t                        sts,
    output logic [COORD_BITS-1:0]          near_x,
    output logic [COORD_BITS-1:0]          near_y,
    output logic [COORD_BITS-1:0]          far_x,
    output logic [COORD_BITS-1:0]          far_y
);

    function automatic logic signed [MUL_BITS-1:0] coord_op(input logic [COORD_BITS-1:0] c);
        return {{(MUL_BITS - COORD_BITS){1'b0}}, c};
    endfunction

    function automatic logic signed [MUL_BITS-1:0] diff_op(input logic [COORD_BITS-1:0] a,
                                                         input logic [COORD_BITS-1:0] b);
        return coord_op(a) - coord_op(b);
    endfunction

    logic signed [RHO_BITS-1:0]  rho_reg;
    logic signed [TRIG_BITS-1:0] cos_reg;
    logic signed [TRIG_BITS-1:0] sin_reg;
    logic [TOL_BITS-1:0]         tol_reg;
    logic                        absent_reg;

    logic [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [COORD_BITS-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [COORD_BITS-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic [COORD_BITS-1:0] nx_reg, ny_reg, fx_reg, fy_reg;
    logic [DIST_BITS-1:0]  rad_a_reg, dist_reg;
    logic signed [PROD_BITS-1:0] px_reg, py_reg;

    logic signed [MUL_BITS-1:0] mx, my, kx, ky;
    logic signed [RHO_BITS+FRAC_ALIGN-1:0] rho_sh;
    logic signed [SUM_BITS-1:0] rho_term;
    logic signed [SUM_BITS-1:0] sum_val;
    logic [SUM_BITS-1:0]        mag;
    logic [TOL_BITS+FRAC_ALIGN-1:0] tol_sh;
    logic [DIST_BITS-1:0]       sum_d;
    logic                       a_first;
    logic                       bounds_zero;
    logic [COORD_BITS-1:0]      s1x, s1y, s2x, s2y;

    // operand select for the shared multiplier pair
    always_comb
    begin
        mx = '0;
        kx = '0;
        my = '0;
        ky = '0;
        unique case (cmd.op)
            OP_LINE_A:
            begin
                mx = MUL_BITS'(cos_reg);
                kx = coord_op(ax_reg);
                my = MUL_BITS'(sin_reg);
                ky = coord_op(ay_reg);
            end
            OP_LINE_B:
            begin
                mx = MUL_BITS'(cos_reg);
                kx = coord_op(bx_reg);
                my = MUL_BITS'(sin_reg);
                ky = coord_op(by_reg);
            end
            OP_RAD_A:
            begin
                mx = coord_op(ax_reg);
                kx = mx;
                my = coord_op(ay_reg);
                ky = my;
            end
            OP_RAD_B:
            begin
                mx = coord_op(bx_reg);
                kx = mx;
                my = coord_op(by_reg);
                ky = my;
            end
            OP_D_E2P1:
            begin
                mx = diff_op(e2x_reg, p1x_reg);
                kx = mx;
                my = diff_op(e2y_reg, p1y_reg);
                ky = my;
            end
            OP_SPAN1, OP_SPAN2:
            begin
                mx = diff_op(e2x_reg, e1x_reg);
                kx = mx;
                my = diff_op(e2y_reg, e1y_reg);
                ky = my;
            end
            OP_D_E1P2:
            begin
                mx = diff_op(e1x_reg, p2x_reg);
                kx = mx;
                my = diff_op(e1y_reg, p2y_reg);
                ky = my;
            end
            default:
            begin
                mx = '0;
            end
        endcase
    end

    // accumulate stage
    assign rho_sh = {rho_reg, {FRAC_ALIGN{1'b0}}};
    assign tol_sh = {tol_reg, {FRAC_ALIGN{1'b0}}};

    always_comb
    begin
        if (cmd.op == OP_LINE_A || cmd.op == OP_LINE_B)
        begin
            rho_term = SUM_BITS'(rho_sh);
        end
        else
        begin
            rho_term = '0;
        end
        sum_val = SUM_BITS'(px_reg) + SUM_BITS'(py_reg) - rho_term;
        mag     = sum_val[SUM_BITS-1] ? SUM_BITS'(-sum_val) : SUM_BITS'(sum_val);
    end

    assign sum_d       = sum_val[DIST_BITS-1:0];
    assign a_first     = rad_a_reg < sum_d;
    assign bounds_zero = (e1x_reg == '0) && (e1y_reg == '0) && (e2x_reg == '0) && (e2y_reg == '0);

    assign s1x = a_first ? ax_reg : bx_reg;
    assign s1y = a_first ? ay_reg : by_reg;
    assign s2x = a_first ? bx_reg : ax_reg;
    assign s2y = a_first ? by_reg : ay_reg;

    assign sts.near        = mag < SUM_BITS'(tol_sh);
    assign sts.bounds_zero = bounds_zero;
    assign sts.line_absent = absent_reg;

    // config registers and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_reg    <= RHO_RESET;
            cos_reg    <= COS_RESET;
            sin_reg    <= SIN_RESET;
            tol_reg    <= TOL_RESET;
            absent_reg <= 1'b0;
            e1x_reg    <= '0;
            e1y_reg    <= '0;
            e2x_reg    <= '0;
            e2y_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RHO:    rho_reg    <= cfg_data[RHO_BITS-1:0];
                    CFG_COS:    cos_reg    <= cfg_data[TRIG_BITS-1:0];
                    CFG_SIN:    sin_reg    <= cfg_data[TRIG_BITS-1:0];
                    CFG_TOL:    tol_reg    <= cfg_data[TOL_BITS-1:0];
                    CFG_ABSENT: absent_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (cmd.emit)
            begin
                e1x_reg <= '0;
                e1y_reg <= '0;
                e2x_reg <= '0;
                e2y_reg <= '0;
            end
            else if (cmd.acc)
            begin
                if (cmd.op == OP_RAD_B && bounds_zero)
                begin
                    e1x_reg <= s1x;
                    e1y_reg <= s1y;
                    e2x_reg <= s2x;
                    e2y_reg <= s2y;
                end
                else if (cmd.op == OP_SPAN1 && dist_reg > sum_d)
                begin
                    e1x_reg <= p1x_reg;
                    e1y_reg <= p1y_reg;
                end
                else if (cmd.op == OP_SPAN2 && dist_reg > sum_d)
                begin
                    e2x_reg <= p2x_reg;
                    e2y_reg <= p2y_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        px_reg <= mx * kx;
        py_reg <= my * ky;
        if (cmd.capture)
        begin
            ax_reg <= seg_ax;
            ay_reg <= seg_ay;
            bx_reg <= seg_bx;
            by_reg <= seg_by;
        end
        if (cmd.acc)
        begin
            if (cmd.op == OP_RAD_A)
            begin
                rad_a_reg <= sum_d;
            end
            if (cmd.op == OP_RAD_B)
            begin
                p1x_reg <= s1x;
                p1y_reg <= s1y;
                p2x_reg <= s2x;
                p2y_reg <= s2y;
            end
            if (cmd.op == OP_D_E2P1 || cmd.op == OP_D_E1P2)
            begin
                dist_reg <= sum_d;
            end
        end
        if (cmd.emit)
        begin
            nx_reg <= absent_reg ? '0 : e1x_reg;
            ny_reg <= absent_reg ? '0 : e1y_reg;
            fx_reg <= absent_reg ? '0 : e2x_reg;
            fy_reg <= absent_reg ? '0 : e2y_reg;
        end
    end

    assign near_x = nx_reg;
    assign near_y = ny_reg;
    assign far_x  = fx_reg;
    assign far_y  = fy_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/csx_ctrl.sv
`default_nettype none
// controller: sequences the multiply/accumulate steps of one segment and the result beat
module csx_ctrl
    import csx_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire logic    last_segment,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EMIT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   last_reg;
    logic   out_valid_reg;
    logic   slot_free;
    state_t done_state;

    assign in_stall    = state_reg != S_IDLE;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign done_state  = last_reg ? S_EMIT : S_IDLE;
    assign out_valid   = out_valid_reg;

    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.acc     = state_reg == S_ACC;
    assign cmd.emit    = (state_reg == S_EMIT) && slot_free;
    assign cmd.op      = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LINE_A;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= last_segment;
                        op_reg   <= OP_LINE_A;
                        if (sts.line_absent)
                        begin
                            state_reg <= last_segment ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_MUL;
                    unique case (op_reg)
                        OP_LINE_A:
                        begin
                            if (sts.near)
                            begin
                                op_reg <= OP_LINE_B;
                            end
                            else
                            begin
                                state_reg <= done_state;
                            end
                        end
                        OP_LINE_B:
                        begin
                            if (sts.near)
                            begin
                                op_reg <= OP_RAD_A;
                            end
                            else
                            begin
                                state_reg <= done_state;
                            end
                        end
                        OP_RAD_A:  op_reg <= OP_RAD_B;
                        OP_RAD_B:
                        begin
                            if (sts.bounds_zero)
                            begin
                                state_reg <= done_state;
                            end
                            else
                            begin
                                op_reg <= OP_D_E2P1;
                            end
                        end
                        OP_D_E2P1: op_reg <= OP_SPAN1;
                        OP_SPAN1:  op_reg <= OP_D_E1P2;
                        OP_D_E1P2: op_reg <= OP_SPAN2;
                        OP_SPAN2:  state_reg <= done_state;
                        default:   state_reg <= done_state;
                    endcase
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_mul_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |=> state_reg == S_ACC)
        else $error("multiply step not followed by accumulate");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result beat not presented after emit");

    a_absent_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && last_segment && sts.line_absent) |=> state_reg == S_EMIT)
        else $error("last segment with no line did not produce a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

FILE: hw/rtl/collinear_segment_extent.sv
`default_nettype none
// top level: extent of the segments lying on one configured line
//
//  channel | direction | handshake         | beat contents
//  cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//  seg in  | in        | in_valid/in_stall | seg_ax, seg_ay, seg_bx, seg_by, last_segment
//  result  | out       | out_valid/stall   | near_x, near_y, far_x, far_y
//
// after accept, each shared multiplier pair operation is a multiply step then an accumulate step:
// line test A alone if A misses the line; line test B and both radii too for a first match; and
// both span checks for a later match; line_absent skips all; a last segment adds a result beat
// config writes are taken every cycle; reset restores the register defaults and clears the bounds
// a stalled result holds the block only when another last segment finishes behind it
module collinear_segment_extent
    import csx_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [COORD_BITS-1:0]     seg_ax,
    input  wire logic [COORD_BITS-1:0]     seg_ay,
    input  wire logic [COORD_BITS-1:0]     seg_bx,
    input  wire logic [COORD_BITS-1:0]     seg_by,
    input  wire logic                      last_segment,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COORD_BITS-1:0]          near_x,
    output logic [COORD_BITS-1:0]          near_y,
    output logic [COORD_BITS-1:0]          far_x,
    output logic [COORD_BITS-1:0]          far_y
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    csx_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .last_segment (last_segment),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    csx_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg_ax    (seg_ax),
        .seg_ay    (seg_ay),
        .seg_bx    (seg_bx),
        .seg_by    (seg_by),
        .cmd       (cmd),
        .sts       (sts),
        .near_x    (near_x),
        .near_y    (near_y),
        .far_x     (far_x),
        .far_y     (far_y)
    );

endmodule
`default_nettype wire
